### sv/kvi_pkg.sv
// Shared types, field widths and codes for the keyframe vertex interpolator.
// No dependencies; kvi_index, kvi_blend and the top level import this package.
package kvi_pkg;

  localparam int unsigned MAX_FRAMES_DEF   = 16;
  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned NUM_ARRAYS_DEF   = 2;

  localparam int unsigned COMP_W     = 32;
  localparam int unsigned VEC_W      = 3 * COMP_W;
  localparam int unsigned TIME_W     = 17;
  localparam int unsigned FCNT_W     = 5;
  localparam int unsigned VCNT_W     = 9;
  localparam int unsigned FIDX_W     = 4;
  localparam int unsigned VIDX_W     = 8;
  localparam int unsigned BASE_W     = 12;
  localparam int unsigned SCALE_W    = TIME_W + FCNT_W;
  localparam int unsigned DIFF_W     = COMP_W + 1;
  localparam int unsigned PROD_W     = DIFF_W + TIME_W + 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = VCNT_W;

  localparam logic [TIME_W-1:0] T_ONE = TIME_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_INTERP = 2'd2;

  localparam logic REQ_LOAD = 1'b0;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LOADED   = 3'd1,
    ST_TIME     = 3'd2,
    ST_FEW      = 3'd3,
    ST_DISABLED = 3'd4,
    ST_RANGE    = 3'd5
  } status_e;

  typedef struct packed {
    logic                     req_type;
    logic                     which_array;
    logic [FIDX_W-1:0]        frame_index;
    logic [VIDX_W-1:0]        vertex_index;
    logic signed [COMP_W-1:0] in_x;
    logic signed [COMP_W-1:0] in_y;
    logic signed [COMP_W-1:0] in_z;
    logic [TIME_W-1:0]        anim_time;
    logic                     cycle_mode;
  } req_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic [BASE_W-1:0]        frame_base;
    logic [2:0]               status;
  } rsp_t;

  typedef struct packed {
    logic [FCNT_W-1:0] frame_count;
    logic [VCNT_W-1:0] vertex_count;
    logic              enable_interp;
  } cfg_t;

  // Load enables of the pipeline registers, stage 1 through the output.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
    logic eno;
  } pipe_en_t;

  // What the index stages hand to the memory read stage.
  typedef struct packed {
    status_e           status;
    logic [FCNT_W-1:0] prev;
    logic [TIME_W-1:0] weight;
    logic              we;
    logic [VEC_W-1:0]  wdata;
  } idx_t;

endpackage

### sv/kvi_chan_if.sv
// Valid/ready channel carrying one payload struct per transaction.
// The payload type comes from kvi_pkg at the point of instantiation.
interface kvi_chan_if #(parameter type T = logic) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### sv/kvi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for both read copies of the frame store.
module kvi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/kvi_index.sv
// Stages 1 and 2: request checks, time scaling, keyframe selection and
// frame store addressing. Depends on kvi_pkg.
module kvi_index import kvi_pkg::*; #(
  parameter int unsigned MAX_FRAMES   = MAX_FRAMES_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned NUM_ARRAYS   = NUM_ARRAYS_DEF,
  parameter int unsigned AW           = 13
) (
  input  logic          clk_i,
  input  pipe_en_t      en_i,
  input  req_t          req_i,
  input  cfg_t          cfg_i,
  output idx_t          s2_o,
  output logic [AW-1:0] addr_a_o,
  output logic [AW-1:0] addr_b_o
);

  // Stage 1: scale the time by the frame span and sort out early errors.
  logic [FCNT_W-1:0]  span;
  logic [SCALE_W-1:0] scaled_d;
  status_e            pre_d;

  req_t               r1_q;
  logic [SCALE_W-1:0] scaled_q;
  status_e            pre_q;

  assign span     = req_i.cycle_mode ? cfg_i.frame_count : cfg_i.frame_count - FCNT_W'(1);
  assign scaled_d = SCALE_W'(req_i.anim_time) * SCALE_W'(span);

  always_comb begin
    if (req_i.req_type == REQ_LOAD) begin
      if (32'(req_i.which_array) >= NUM_ARRAYS || 32'(req_i.frame_index) >= MAX_FRAMES ||
          32'(req_i.vertex_index) >= MAX_VERTICES) begin
        pre_d = ST_RANGE;
      end else begin
        pre_d = ST_LOADED;
      end
    end else if (req_i.anim_time > T_ONE) begin
      pre_d = ST_TIME;
    end else if (cfg_i.frame_count < FCNT_W'(2)) begin
      pre_d = ST_FEW;
    end else if (32'(cfg_i.frame_count) > MAX_FRAMES ||
                 32'(cfg_i.vertex_count) > MAX_VERTICES ||
                 32'(req_i.which_array) >= NUM_ARRAYS) begin
      pre_d = ST_RANGE;
    end else begin
      pre_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      r1_q     <= req_i;
      scaled_q <= scaled_d;
      pre_q    <= pre_d;
    end
  end

  // Stage 2: previous and next keyframe, blend weight, final status.
  logic [SCALE_W-FRAC_W-1:0] prev_raw;
  logic [FCNT_W-1:0]         limit;
  logic [FCNT_W-1:0]         prev;
  logic [FCNT_W-1:0]         prev_inc;
  logic [FCNT_W-1:0]         next;
  logic [FCNT_W-1:0]         frame_sel;
  logic [SCALE_W-1:0]        weight_full;
  logic [31:0]               slot_a;
  logic [31:0]               slot_b;
  idx_t                      s2_d;
  idx_t                      s2_q;
  logic [AW-1:0]             addr_a_q;
  logic [AW-1:0]             addr_b_q;

  assign prev_raw = scaled_q[SCALE_W-1:FRAC_W];
  assign limit    = r1_q.cycle_mode ? cfg_i.frame_count - FCNT_W'(1)
                                    : cfg_i.frame_count - FCNT_W'(2);
  assign prev     = (prev_raw > (SCALE_W-FRAC_W)'(limit)) ? limit : FCNT_W'(prev_raw);
  assign prev_inc = prev + FCNT_W'(1);
  // Looping animations wrap from the last keyframe back to the first.
  assign next     = (r1_q.cycle_mode && prev_inc == cfg_i.frame_count) ? '0 : prev_inc;
  assign weight_full = scaled_q - SCALE_W'({prev, {FRAC_W{1'b0}}});

  assign frame_sel = (r1_q.req_type == REQ_LOAD) ? FCNT_W'(r1_q.frame_index) : prev;
  assign slot_a = (32'(r1_q.which_array) * MAX_FRAMES + 32'(frame_sel)) * MAX_VERTICES +
                  32'(r1_q.vertex_index);
  assign slot_b = (32'(r1_q.which_array) * MAX_FRAMES + 32'(next)) * MAX_VERTICES +
                  32'(r1_q.vertex_index);

  always_comb begin
    s2_d.prev   = prev;
    s2_d.weight = weight_full[TIME_W-1:0];
    s2_d.we     = (pre_q == ST_LOADED);
    s2_d.wdata  = {r1_q.in_z, r1_q.in_y, r1_q.in_x};
    if (pre_q != ST_OK) begin
      s2_d.status = pre_q;
    end else if (!cfg_i.enable_interp) begin
      s2_d.status = ST_DISABLED;
    end else if (VCNT_W'(r1_q.vertex_index) >= cfg_i.vertex_count) begin
      s2_d.status = ST_RANGE;
    end else begin
      s2_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      s2_q     <= s2_d;
      addr_a_q <= AW'(slot_a);
      addr_b_q <= AW'(slot_b);
    end
  end

  assign s2_o     = s2_q;
  assign addr_a_o = addr_a_q;
  assign addr_b_o = addr_b_q;

endmodule

### sv/kvi_blend.sv
// Stages 4, 5 and output: a + round((b - a) * w / 65536) for one component.
// Depends on kvi_pkg.
module kvi_blend import kvi_pkg::*; (
  input  logic              clk_i,
  input  pipe_en_t          en_i,
  input  logic [COMP_W-1:0] a_i,
  input  logic [COMP_W-1:0] b_i,
  input  logic [TIME_W-1:0] weight_i,
  input  logic              keep_i,
  output logic [COMP_W-1:0] res_o
);

  logic [COMP_W-1:0]        a4_q;
  logic signed [DIFF_W-1:0] diff_d;
  logic signed [DIFF_W-1:0] diff_q;
  logic [TIME_W-1:0]        weight4_q;

  logic [COMP_W-1:0]        a5_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] quot;
  logic [COMP_W-1:0]        res_d;
  logic [COMP_W-1:0]        res_q;

  assign diff_d = $signed({b_i[COMP_W-1], b_i}) - $signed({a_i[COMP_W-1], a_i});
  assign prod_d = diff_q * $signed({1'b0, weight4_q});

  // Round half up, then floor-shift back to Q16.16.
  assign rounded = prod_q + $signed(PROD_W'(32768));
  assign quot    = rounded >>> FRAC_W;
  assign res_d   = a5_q + quot[COMP_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.en4) begin
      a4_q      <= a_i;
      diff_q    <= diff_d;
      weight4_q <= weight_i;
    end
    if (en_i.en5) begin
      a5_q   <= a4_q;
      prod_q <= prod_d;
    end
    if (en_i.eno) begin
      res_q <= keep_i ? res_d : '0;
    end
  end

  assign res_o = res_q;

endmodule

### sv/keyframe_vertex_interpolator.sv
// Top level of the keyframe vertex interpolator: pipeline control, frame store
// and result assembly. Depends on kvi_pkg, kvi_chan_if, kvi_ram, kvi_index, kvi_blend.
//
//   Channel   Direction  Handshake            Payload
//   req_i     in         valid / ready        kvi_pkg::req_t (load or query)
//   rsp_o     out        valid / ready        kvi_pkg::rsp_t (vector, base, status)
//   cfg_*_i   in         write enable only    register index and data
//
// One transaction is accepted per clock unless every stage is full and the result
// is stalled; its result passes two index stages, the store read, the difference,
// the multiply and the output register.
// Reset clears the valid bits and the configuration; the frame store is not cleared.
// Each stage holds when it is full and the next one cannot take its content, so
// bubbles close up and input is taken while a finished result waits.
module keyframe_vertex_interpolator import kvi_pkg::*; #(
  parameter int unsigned MAX_FRAMES   = MAX_FRAMES_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned NUM_ARRAYS   = NUM_ARRAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kvi_chan_if.sink              req_i,
  kvi_chan_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // One entry per array, keyframe and vertex, laid out array-major.
  localparam int unsigned STORE_DEPTH = NUM_ARRAYS * MAX_FRAMES * MAX_VERTICES;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);

  // Configuration registers. The user must change them only while the pipeline is empty,
  // which the block does not enforce; every stage reads them directly.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count   <= '0;
      cfg_q.vertex_count  <= '0;
      cfg_q.enable_interp <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_COUNT:   cfg_q.frame_count   <= cfg_wdata_i[FCNT_W-1:0];
        CFG_VERTEX_COUNT:  cfg_q.vertex_count  <= cfg_wdata_i[VCNT_W-1:0];
        CFG_ENABLE_INTERP: cfg_q.enable_interp <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Valid bits and the stall chain. A stage loads when it is empty or when
  // its content moves on in the same cycle.
  logic     v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  pipe_en_t en;

  assign en.eno = !vo_q || rsp_o.ready;
  assign en.en5 = !v5_q || en.eno;
  assign en.en4 = !v4_q || en.en5;
  assign en.en3 = !v3_q || en.en4;
  assign en.en2 = !v2_q || en.en3;
  assign en.en1 = !v1_q || en.en2;

  assign req_i.ready = en.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en.en1) begin
        v1_q <= req_i.valid;
      end
      if (en.en2) begin
        v2_q <= v1_q;
      end
      if (en.en3) begin
        v3_q <= v2_q;
      end
      if (en.en4) begin
        v4_q <= v3_q;
      end
      if (en.en5) begin
        v5_q <= v4_q;
      end
      if (en.eno) begin
        vo_q <= v5_q;
      end
    end
  end

  // Stages 1 and 2: checks, keyframe choice and store addresses.
  idx_t          s2;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;

  kvi_index #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_VERTICES(MAX_VERTICES),
    .NUM_ARRAYS  (NUM_ARRAYS),
    .AW          (AW)
  ) u_index (
    .clk_i   (clk_i),
    .en_i    (en),
    .req_i   (req_i.data),
    .cfg_i   (cfg_q),
    .s2_o    (s2),
    .addr_a_o(addr_a),
    .addr_b_o(addr_b)
  );

  // Stage 3: the frame store. Two copies, written together, give the previous
  // and next keyframe in the same cycle. A load writes as it leaves stage 2;
  // reads advance only with stage 3 so a stall keeps the read data.
  logic             store_we;
  logic [VEC_W-1:0] vec_a;
  logic [VEC_W-1:0] vec_b;

  assign store_we = en.en3 && v2_q && s2.we;

  kvi_ram #(
    .WIDTH(VEC_W),
    .DEPTH(STORE_DEPTH)
  ) u_store_prev (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(addr_a),
    .wdata_i(s2.wdata),
    .re_i   (en.en3),
    .raddr_i(addr_a),
    .rdata_o(vec_a)
  );

  kvi_ram #(
    .WIDTH(VEC_W),
    .DEPTH(STORE_DEPTH)
  ) u_store_next (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(addr_a),
    .wdata_i(s2.wdata),
    .re_i   (en.en3),
    .raddr_i(addr_b),
    .rdata_o(vec_b)
  );

  // Status and base offset travel beside the blend datapath. The base offset
  // is kept only for a good result or for a disabled query.
  status_e           st3_q, st4_q, st5_q, st_o_q;
  logic [BASE_W-1:0] base3_d, base3_q, base4_q, base5_q, base_o_q;
  logic [TIME_W-1:0] weight3_q;

  assign base3_d = (s2.status == ST_OK || s2.status == ST_DISABLED)
                 ? BASE_W'(s2.prev) * BASE_W'(cfg_q.vertex_count) : '0;

  always_ff @(posedge clk_i) begin
    if (en.en3) begin
      st3_q     <= s2.status;
      base3_q   <= base3_d;
      weight3_q <= s2.weight;
    end
    if (en.en4) begin
      st4_q   <= st3_q;
      base4_q <= base3_q;
    end
    if (en.en5) begin
      st5_q   <= st4_q;
      base5_q <= base4_q;
    end
    if (en.eno) begin
      st_o_q   <= st5_q;
      base_o_q <= base5_q;
    end
  end

  // Stages 4, 5 and output: one blend lane per component.
  logic              keep;
  logic [COMP_W-1:0] res_x, res_y, res_z;

  assign keep = (st5_q == ST_OK);

  kvi_blend u_blend_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (vec_a[COMP_W-1:0]),
    .b_i     (vec_b[COMP_W-1:0]),
    .weight_i(weight3_q),
    .keep_i  (keep),
    .res_o   (res_x)
  );

  kvi_blend u_blend_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (vec_a[2*COMP_W-1:COMP_W]),
    .b_i     (vec_b[2*COMP_W-1:COMP_W]),
    .weight_i(weight3_q),
    .keep_i  (keep),
    .res_o   (res_y)
  );

  kvi_blend u_blend_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (vec_a[3*COMP_W-1:2*COMP_W]),
    .b_i     (vec_b[3*COMP_W-1:2*COMP_W]),
    .weight_i(weight3_q),
    .keep_i  (keep),
    .res_o   (res_z)
  );

  rsp_t rsp_d;

  always_comb begin
    rsp_d.out_x      = res_x;
    rsp_d.out_y      = res_y;
    rsp_d.out_z      = res_z;
    rsp_d.frame_base = base_o_q;
    rsp_d.status     = st_o_q;
  end

  assign rsp_o.valid = vo_q;
  assign rsp_o.data  = rsp_d;

`ifndef ASSERT_OFF
  // Input is refused only when every stage is full and the result is stalled.
  a_full_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (rsp_o.valid && !rsp_o.ready))
    else $error("input refused while the pipeline could still advance");

  // A result appears only when stage 5 held a transaction.
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vo_q) |-> $past(v5_q))
    else $error("result valid without a transaction in stage 5");

  // Anything but a good blend carries a zero vector.
  a_zero_vector_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && st_o_q != ST_OK) |-> (res_x == '0 && res_y == '0 && res_z == '0))
    else $error("nonzero vector with a non-ok status");

  // The base offset survives only for a good result or a disabled query.
  a_base_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && st_o_q != ST_OK && st_o_q != ST_DISABLED) |-> (base_o_q == '0))
    else $error("base offset reported with an error status");
`endif

endmodule
